@@ design/pha_pkg.sv @@
// Shared types, codes and fixed-point helpers for the pixel hit alignment block.
package pha_pkg;

  localparam int WORDS_PER_PLANE = 12;
  localparam int TRIG_FRAC       = 30;
  localparam int LOCAL_PROD_FRAC = 28;

  typedef logic signed [31:0] word_t;
  typedef word_t [WORDS_PER_PLANE-1:0] plane_words_t;

  typedef enum logic {
    OP_HIT  = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // Alignment word slots within a plane
  typedef enum logic [3:0] {
    W_COS_L   = 4'd0,
    W_SIN_L   = 4'd1,
    W_OFF_LX  = 4'd2,
    W_OFF_LY  = 4'd3,
    W_OFF_LZ  = 4'd4,
    W_COS_GZ  = 4'd5,
    W_SIN_GZ  = 4'd6,
    W_OFF_GX  = 4'd7,
    W_OFF_GY  = 4'd8,
    W_OFF_GZ  = 4'd9,
    W_COS_GY  = 4'd10,
    W_SIN_GY  = 4'd11
  } word_sel_t;

  typedef enum logic [1:0] {
    REG_PITCH_X  = 2'd0,
    REG_PITCH_Y  = 2'd1,
    REG_CENTER_X = 2'd2,
    REG_CENTER_Y = 2'd3
  } reg_idx_t;

  localparam logic [19:0] PITCH_X_RST  = 20'd157286;
  localparam logic [19:0] PITCH_Y_RST  = 20'd104858;
  localparam logic [15:0] CENTER_X_RST = 16'd0;
  localparam logic [15:0] CENTER_Y_RST = 16'd0;

  localparam logic signed [39:0] SAT_HI = 40'sh00_7FFF_FFFF;
  localparam logic signed [39:0] SAT_LO = 40'shFF_8000_0000;

  // Clamp to the signed 32-bit range
  function automatic word_t sat32(input logic signed [39:0] v);
    word_t r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Per-hit bundle carried down the pipeline
  typedef struct packed {
    logic         found;
    word_t        lx;
    word_t        ly;
    word_t        tx;
    word_t        ty;
    word_t        tz;
    word_t        gzz;
    word_t        gyz;
    plane_words_t w;
  } side_t;

endpackage

@@ design/pha_table.sv @@
// Per-plane alignment word memories and plane-present bits.
module pha_table #(
  parameter int NUM_CHANNELS       = 8,
  parameter int PLANES_PER_CHANNEL = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ld,
  input  logic [2:0]            channel,
  input  logic [2:0]            plane,
  input  logic [3:0]            word_select,
  input  pha_pkg::word_t        word_value,
  output pha_pkg::plane_words_t words,
  output logic                  found
);
  import pha_pkg::*;

  localparam int NUM_PLANES = NUM_CHANNELS * PLANES_PER_CHANNEL;
  localparam int PIDX_W     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  logic                  in_range;
  logic [PIDX_W-1:0]     pidx;
  logic [NUM_PLANES-1:0] present;

  assign in_range = (32'(channel) < NUM_CHANNELS) && (32'(plane) < PLANES_PER_CHANNEL);
  assign pidx     = PIDX_W'(32'(channel) * PLANES_PER_CHANNEL + 32'(plane));

  // One memory per word slot so a hit reads all twelve words at once
  for (genvar g = 0; g < WORDS_PER_PLANE; g++) begin : g_mem
    word_t mem [NUM_PLANES];

    always_ff @(posedge clk) begin
      if (ld && in_range && (word_select == 4'(g))) begin
        mem[pidx] <= word_value;
      end
      words[g] <= mem[pidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (ld && in_range && (32'(word_select) < WORDS_PER_PLANE)) begin
      present[pidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    found <= in_range && present[pidx];
  end

endmodule

@@ design/pha_local.sv @@
// Pixel index to local millimetres: pitch * (index - centre), two lanes, three stages.
module pha_local #(
  parameter int COORD_FRAC_BITS = 20
) (
  input  logic           clk,
  input  logic [7:0]     column,
  input  logic [7:0]     row,
  input  logic [19:0]    pitch_x,
  input  logic [19:0]    pitch_y,
  input  logic [15:0]    center_x,
  input  logic [15:0]    center_y,
  output pha_pkg::word_t loc_x,
  output pha_pkg::word_t loc_y
);
  import pha_pkg::*;

  localparam int SHIFT = LOCAL_PROD_FRAC - COORD_FRAC_BITS;
  localparam logic signed [38:0] LOC_RND = 39'((64'd1 << SHIFT) >> 1);

  logic [7:0]         idx   [2];
  logic [19:0]        pitch [2];
  logic [15:0]        ctr   [2];
  logic signed [16:0] delta [2];
  logic signed [37:0] prod  [2];
  logic signed [38:0] rnd   [2];
  word_t              loc   [2];

  assign idx[0]   = column;
  assign idx[1]   = row;
  assign pitch[0] = pitch_x;
  assign pitch[1] = pitch_y;
  assign ctr[0]   = center_x;
  assign ctr[1]   = center_y;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    assign rnd[g] = (39'(prod[g]) + LOC_RND) >>> SHIFT;

    always_ff @(posedge clk) begin
      delta[g] <= $signed({1'b0, idx[g], 8'h00}) - $signed({1'b0, ctr[g]});
      prod[g]  <= $signed({1'b0, pitch[g]}) * delta[g];
      loc[g]   <= sat32(40'(rnd[g]));
    end
  end

  assign loc_x = loc[0];
  assign loc_y = loc[1];

endmodule

@@ design/pha_rotate.sv @@
// Planar rotation plus offset with round-to-nearest and saturation, three stages.
module pha_rotate (
  input  logic           clk,
  input  pha_pkg::word_t ax,
  input  pha_pkg::word_t ay,
  input  pha_pkg::word_t cs,
  input  pha_pkg::word_t sn,
  input  pha_pkg::word_t ox,
  input  pha_pkg::word_t oy,
  output pha_pkg::word_t rx,
  output pha_pkg::word_t ry
);
  import pha_pkg::*;

  localparam logic signed [64:0] ROT_RND = 65'sd1 <<< (TRIG_FRAC - 1);

  logic signed [63:0] p_ac, p_as, p_xs, p_yc;
  logic signed [64:0] sum_x, sum_y;
  word_t              ox_d1, oy_d1, ox_d2, oy_d2;
  logic signed [34:0] sh_x, sh_y;
  logic signed [35:0] off_x, off_y;

  assign sh_x  = 35'(sum_x >>> TRIG_FRAC);
  assign sh_y  = 35'(sum_y >>> TRIG_FRAC);
  assign off_x = 36'(sh_x) + 36'(ox_d2);
  assign off_y = 36'(sh_y) + 36'(oy_d2);

  always_ff @(posedge clk) begin
    p_ac  <= ax * cs;
    p_as  <= ay * sn;
    p_xs  <= ax * sn;
    p_yc  <= ay * cs;
    ox_d1 <= ox;
    oy_d1 <= oy;

    sum_x <= 65'(p_ac) - 65'(p_as) + ROT_RND;
    sum_y <= 65'(p_xs) + 65'(p_yc) + ROT_RND;
    ox_d2 <= ox_d1;
    oy_d2 <= oy_d1;

    rx <= sat32(40'(off_x));
    ry <= sat32(40'(off_y));
  end

endmodule

@@ design/pixel_hit_rigid_alignment.sv @@
// Top level: pixel hit alignment pipeline with APB register port.
//
//   channel   direction  handshake                  payload
//   command   in         start & !busy              opcode channel plane word_select
//                                                   word_value column row
//   result    out        done strobe, one cycle     found local_x/y tel_x/y/z glob_x/y/z
//   config    in/out     APB psel/penable/pready    pitch_x pitch_y center_x center_y
//
// One item per cycle while busy is low. A hit's result reaches the ports with its
// done strobe, after three stages of pixel scaling (the table read runs beside the
// first), three for each of the three rotation units (multiply, sum, round and
// clamp), then the output register.
// Loads give no result and are visible to a hit transferred in the next cycle.
// Reset restores the registers, clears the plane-present bits and holds busy high
// through reset and until the first edge that samples reset low; alignment words hold
// no value until loaded. Results cannot be held off, so the pipeline never stalls.
module pixel_hit_rigid_alignment #(
  parameter int NUM_CHANNELS       = 8,
  parameter int PLANES_PER_CHANNEL = 8,
  parameter int COORD_FRAC_BITS    = 20
) (
  input  logic           clk,
  input  logic           rst,

  input  logic           start,
  output logic           busy,
  input  logic           opcode,
  input  logic [2:0]     channel,
  input  logic [2:0]     plane,
  input  logic [3:0]     word_select,
  input  pha_pkg::word_t word_value,
  input  logic [7:0]     column,
  input  logic [7:0]     row,

  output logic           done,
  output logic           found,
  output pha_pkg::word_t local_x,
  output pha_pkg::word_t local_y,
  output pha_pkg::word_t tel_x,
  output pha_pkg::word_t tel_y,
  output pha_pkg::word_t tel_z,
  output pha_pkg::word_t glob_x,
  output pha_pkg::word_t glob_y,
  output pha_pkg::word_t glob_z,

  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import pha_pkg::*;

  localparam int LAST = 12;

  logic         xfer, hit_xfer, load_xfer, reg_wr;
  logic [19:0]  pitch_x, pitch_y;
  logic [15:0]  center_x, center_y;
  logic [LAST:1] vld;

  plane_words_t tbl_words;
  logic         tbl_found;
  word_t        loc_x, loc_y;
  word_t        tel_rx, tel_ry, gz_rx, gz_ry, gy_rx, gy_ry;

  side_t side      [2:LAST];
  side_t side_next [2:LAST];

  assign xfer      = start && !busy;
  assign hit_xfer  = xfer && (opcode == OP_HIT);
  assign load_xfer = xfer && (opcode == OP_LOAD);

  // Register port
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_x  <= PITCH_X_RST;
      pitch_y  <= PITCH_Y_RST;
      center_x <= CENTER_X_RST;
      center_y <= CENTER_Y_RST;
    end else if (reg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_PITCH_X:  pitch_x  <= pwdata[19:0];
        REG_PITCH_Y:  pitch_y  <= pwdata[19:0];
        REG_CENTER_X: center_x <= pwdata[15:0];
        REG_CENTER_Y: center_y <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_PITCH_X:  prdata = {12'h000, pitch_x};
      REG_PITCH_Y:  prdata = {12'h000, pitch_y};
      REG_CENTER_X: prdata = {16'h0000, center_x};
      REG_CENTER_Y: prdata = {16'h0000, center_y};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[LAST-1:1], hit_xfer};
      done <= vld[LAST];
    end
  end

  pha_table #(
    .NUM_CHANNELS       (NUM_CHANNELS),
    .PLANES_PER_CHANNEL (PLANES_PER_CHANNEL)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .ld          (load_xfer),
    .channel     (channel),
    .plane       (plane),
    .word_select (word_select),
    .word_value  (word_value),
    .words       (tbl_words),
    .found       (tbl_found)
  );

  pha_local #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_local (
    .clk      (clk),
    .column   (column),
    .row      (row),
    .pitch_x  (pitch_x),
    .pitch_y  (pitch_y),
    .center_x (center_x),
    .center_y (center_y),
    .loc_x    (loc_x),
    .loc_y    (loc_y)
  );

  // Local rotation + offset: enters at stage 3, tx/ty out at stage 6
  pha_rotate u_rot_tel (
    .clk (clk),
    .ax  (loc_x),
    .ay  (loc_y),
    .cs  (word_t'(side[3].w[W_COS_L])),
    .sn  (word_t'(side[3].w[W_SIN_L])),
    .ox  (word_t'(side[3].w[W_OFF_LX])),
    .oy  (word_t'(side[3].w[W_OFF_LY])),
    .rx  (tel_rx),
    .ry  (tel_ry)
  );

  // Global Z rotation + offsets: enters at stage 6, gxz/gyz out at stage 9
  pha_rotate u_rot_gz (
    .clk (clk),
    .ax  (tel_rx),
    .ay  (tel_ry),
    .cs  (word_t'(side[6].w[W_COS_GZ])),
    .sn  (word_t'(side[6].w[W_SIN_GZ])),
    .ox  (word_t'(side[6].w[W_OFF_GX])),
    .oy  (word_t'(side[6].w[W_OFF_GY])),
    .rx  (gz_rx),
    .ry  (gz_ry)
  );

  // Global Y rotation with z leading: rx is global z, ry is global x
  pha_rotate u_rot_gy (
    .clk (clk),
    .ax  (side[9].gzz),
    .ay  (gz_rx),
    .cs  (word_t'(side[9].w[W_COS_GY])),
    .sn  (word_t'(side[9].w[W_SIN_GY])),
    .ox  ('0),
    .oy  ('0),
    .rx  (gy_rx),
    .ry  (gy_ry)
  );

  always_comb begin
    side_next[2]       = '0;
    side_next[2].found = tbl_found;
    side_next[2].w     = tbl_words;
    side_next[2].tz    = word_t'(tbl_words[W_OFF_LZ]);
    side_next[2].gzz   = sat32(40'(word_t'(tbl_words[W_OFF_LZ])) +
                               40'(word_t'(tbl_words[W_OFF_GZ])));
    for (int s = 3; s <= LAST; s++) begin
      side_next[s] = side[s-1];
    end
    // Merge unit results as they come out
    side_next[4].lx   = loc_x;
    side_next[4].ly   = loc_y;
    side_next[7].tx   = tel_rx;
    side_next[7].ty   = tel_ry;
    side_next[10].gyz = gz_ry;
  end

  always_ff @(posedge clk) begin
    for (int s = 2; s <= LAST; s++) begin
      side[s] <= side_next[s];
    end
  end

  // Result register; a missing plane reports all zero
  always_ff @(posedge clk) begin
    found <= side[LAST].found;
    if (side[LAST].found) begin
      local_x <= side[LAST].lx;
      local_y <= side[LAST].ly;
      tel_x   <= side[LAST].tx;
      tel_y   <= side[LAST].ty;
      tel_z   <= side[LAST].tz;
      glob_x  <= gy_ry;
      glob_y  <= side[LAST].gyz;
      glob_z  <= gy_rx;
    end else begin
      local_x <= '0;
      local_y <= '0;
      tel_x   <= '0;
      tel_y   <= '0;
      tel_z   <= '0;
      glob_x  <= '0;
      glob_y  <= '0;
      glob_z  <= '0;
    end
  end

  a_done_from_hit : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (opcode == OP_HIT), LAST + 1))
    else $error("result strobe without a matching hit transfer");

  a_load_silent : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == OP_LOAD)) |-> ##(LAST + 1) !done)
    else $error("load transfer produced a result");

  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (local_x == 0 && local_y == 0 && tel_x == 0 && tel_y == 0 &&
                          tel_z == 0 && glob_x == 0 && glob_y == 0 && glob_z == 0))
    else $error("missing plane result carries nonzero fields");

  a_busy_reset_only : assert property (@(posedge clk) disable iff (rst)
    busy |-> $past(rst))
    else $error("busy high outside reset recovery");

endmodule
